>>> rtl/nlqt_pkg.sv
// nlqt_pkg: shared types and constants of the neighbour link-quality tracker
// used by every module under rtl/, depends on nothing else
`default_nettype none

package nlqt_pkg;

    // default size of the neighbour table
    localparam int NEIGHBOURS_DEF = 64;

    // widths of the fixed fields
    localparam int MODE_W  = 2;
    localparam int NB_W    = 6;
    localparam int STATE_W = 2;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // saturation limit of the packet count
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // register reset values
    localparam logic [7:0] NULL_TO_ACTIVE_RST      = 8'd5;
    localparam logic [7:0] NULL_TO_UNSTABLE_RST    = 8'd1;
    localparam logic [7:0] ACTIVE_KEEP_RST         = 8'd4;
    localparam logic [7:0] UNSTABLE_TO_ACTIVE_RST  = 8'd4;
    localparam logic [7:0] EXPIRED_TO_ACTIVE_RST   = 8'd5;
    localparam logic [7:0] EXPIRED_TO_UNSTABLE_RST = 8'd1;
    localparam logic [7:0] EXPIRE_LEVEL_RST        = 8'd0;

    // link quality, ordered from worst to best
    typedef enum logic [STATE_W-1:0] {
        ST_NULL     = 2'd0,
        ST_EXPIRED  = 2'd1,
        ST_UNSTABLE = 2'd2,
        ST_ACTIVE   = 2'd3
    } link_state_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_UP    = 2'd0,
        MODE_DOWN  = 2'd1,
        MODE_MSG   = 2'd2,
        MODE_TIMER = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NULL_TO_ACTIVE      = 3'd0,
        REG_NULL_TO_UNSTABLE    = 3'd1,
        REG_ACTIVE_KEEP         = 3'd2,
        REG_UNSTABLE_TO_ACTIVE  = 3'd3,
        REG_EXPIRED_TO_ACTIVE   = 3'd4,
        REG_EXPIRED_TO_UNSTABLE = 3'd5,
        REG_EXPIRE_LEVEL        = 3'd6
    } cfg_idx_t;

    // table initialization sequencer
    typedef enum logic {
        INIT_CLEAR = 1'b0,
        INIT_RUN   = 1'b1
    } init_state_t;

    typedef struct packed {
        logic [7:0] null_to_active_min;
        logic [7:0] null_to_unstable_min;
        logic [7:0] active_keep_min;
        logic [7:0] unstable_to_active_min;
        logic [7:0] expired_to_active_min;
        logic [7:0] expired_to_unstable_min;
        logic [7:0] expire_level;
    } cfg_t;

    // one table entry; all zero is the cleared entry
    typedef struct packed {
        link_state_t         link;
        link_state_t         earlier;
        logic [COUNT_W-1:0]  count;
    } entry_t;

    typedef struct packed {
        logic                changed;
        link_state_t         link;
        link_state_t         earlier;
        logic [COUNT_W-1:0]  count;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/nlqt_cfg_regs.sv
// nlqt_cfg_regs: threshold register file of the link-quality tracker
// depends on nlqt_pkg
`default_nettype none

module nlqt_cfg_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                wr_en,
    input  wire logic [nlqt_pkg::CFG_IDX_W-1:0]      wr_index,
    input  wire logic [nlqt_pkg::CFG_DATA_W-1:0]     wr_data,
    output nlqt_pkg::cfg_t                           cfg
);

    nlqt_pkg::cfg_t cfg_reg;
    nlqt_pkg::cfg_t cfg_next;

    // decode the write, unknown indexes leave everything alone
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (nlqt_pkg::cfg_idx_t'(wr_index))
                nlqt_pkg::REG_NULL_TO_ACTIVE:      cfg_next.null_to_active_min      = wr_data;
                nlqt_pkg::REG_NULL_TO_UNSTABLE:    cfg_next.null_to_unstable_min    = wr_data;
                nlqt_pkg::REG_ACTIVE_KEEP:         cfg_next.active_keep_min         = wr_data;
                nlqt_pkg::REG_UNSTABLE_TO_ACTIVE:  cfg_next.unstable_to_active_min  = wr_data;
                nlqt_pkg::REG_EXPIRED_TO_ACTIVE:   cfg_next.expired_to_active_min   = wr_data;
                nlqt_pkg::REG_EXPIRED_TO_UNSTABLE: cfg_next.expired_to_unstable_min = wr_data;
                nlqt_pkg::REG_EXPIRE_LEVEL:        cfg_next.expire_level            = wr_data;
                default:                           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.null_to_active_min      <= nlqt_pkg::NULL_TO_ACTIVE_RST;
            cfg_reg.null_to_unstable_min    <= nlqt_pkg::NULL_TO_UNSTABLE_RST;
            cfg_reg.active_keep_min         <= nlqt_pkg::ACTIVE_KEEP_RST;
            cfg_reg.unstable_to_active_min  <= nlqt_pkg::UNSTABLE_TO_ACTIVE_RST;
            cfg_reg.expired_to_active_min   <= nlqt_pkg::EXPIRED_TO_ACTIVE_RST;
            cfg_reg.expired_to_unstable_min <= nlqt_pkg::EXPIRED_TO_UNSTABLE_RST;
            cfg_reg.expire_level            <= nlqt_pkg::EXPIRE_LEVEL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/nlqt_table.sv
// nlqt_table: per-neighbour entry memory with a clearing pass after reset
// one registered read port, one write port; depends on nlqt_pkg
`default_nettype none

module nlqt_table #(
    parameter int NEIGHBOURS = nlqt_pkg::NEIGHBOURS_DEF,
    parameter int AW         = $clog2(NEIGHBOURS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output nlqt_pkg::entry_t      rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire nlqt_pkg::entry_t wr_data,
    output logic                  ready
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(NEIGHBOURS - 1);

    nlqt_pkg::entry_t mem [NEIGHBOURS];
    nlqt_pkg::entry_t rd_data_reg;

    nlqt_pkg::init_state_t state_reg;
    nlqt_pkg::init_state_t state_next;
    logic [AW-1:0]         clr_addr_reg;
    logic [AW-1:0]         clr_addr_next;
    logic                  clr_active;

    // next state of the clearing sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nlqt_pkg::INIT_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                    state_next = nlqt_pkg::INIT_RUN;
            end
            nlqt_pkg::INIT_RUN:
            begin
                state_next = nlqt_pkg::INIT_RUN;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        clr_active = (state_reg == nlqt_pkg::INIT_CLEAR);
        ready      = (state_reg == nlqt_pkg::INIT_RUN);
    end

    // clear address walks the table once
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        if (clr_active)
            clr_addr_next = clr_addr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= nlqt_pkg::INIT_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // memory array, read-before-write on the same address
    always_ff @(posedge clk)
    begin
        if (clr_active)
            mem[clr_addr_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/nlqt_update.sv
// nlqt_update: entry update for one request, count moves and state evaluation
// combinational only; depends on nlqt_pkg
`default_nettype none

module nlqt_update (
    input  wire nlqt_pkg::entry_t  cur,
    input  wire nlqt_pkg::mode_t   mode,
    input  wire nlqt_pkg::cfg_t    cfg,
    output nlqt_pkg::entry_t       nxt,
    output nlqt_pkg::res_t         res
);

    // threshold evaluation of one state
    function automatic nlqt_pkg::link_state_t eval_link(
        input nlqt_pkg::link_state_t s,
        input logic [7:0]            c,
        input nlqt_pkg::cfg_t        g
    );
        nlqt_pkg::link_state_t r;
        begin
            r = s;
            unique case (s)
                nlqt_pkg::ST_NULL:
                begin
                    if (c >= g.null_to_active_min)        r = nlqt_pkg::ST_ACTIVE;
                    else if (c >= g.null_to_unstable_min) r = nlqt_pkg::ST_UNSTABLE;
                    else                                  r = nlqt_pkg::ST_NULL;
                end
                nlqt_pkg::ST_ACTIVE:
                begin
                    if (c <= g.expire_level)         r = nlqt_pkg::ST_EXPIRED;
                    else if (c < g.active_keep_min)  r = nlqt_pkg::ST_UNSTABLE;
                    else                             r = nlqt_pkg::ST_ACTIVE;
                end
                nlqt_pkg::ST_UNSTABLE:
                begin
                    if (c >= g.unstable_to_active_min) r = nlqt_pkg::ST_ACTIVE;
                    else if (c <= g.expire_level)      r = nlqt_pkg::ST_EXPIRED;
                    else                               r = nlqt_pkg::ST_UNSTABLE;
                end
                nlqt_pkg::ST_EXPIRED:
                begin
                    if (c >= g.expired_to_active_min)        r = nlqt_pkg::ST_ACTIVE;
                    else if (c >= g.expired_to_unstable_min) r = nlqt_pkg::ST_UNSTABLE;
                    else                                     r = nlqt_pkg::ST_NULL;
                end
            endcase
            return r;
        end
    endfunction

    nlqt_pkg::link_state_t cand;
    logic                  move_ok;

    assign cand = eval_link(cur.link, cur.count, cfg);

    // a message never takes the state down
    assign move_ok = (cand != cur.link) &&
                     !((mode == nlqt_pkg::MODE_MSG) && (cand < cur.link));

    always_comb
    begin
        nxt         = cur;
        res.changed = 1'b0;
        unique case (mode)
            nlqt_pkg::MODE_UP:
            begin
                if (cur.count != nlqt_pkg::COUNT_MAX)
                    nxt.count = cur.count + 1'b1;
            end
            nlqt_pkg::MODE_DOWN:
            begin
                if (cur.count != '0)
                    nxt.count = cur.count - 1'b1;
            end
            nlqt_pkg::MODE_MSG,
            nlqt_pkg::MODE_TIMER:
            begin
                if (move_ok)
                begin
                    nxt.link    = cand;
                    nxt.earlier = cur.link;
                    res.changed = 1'b1;
                end
                if (mode == nlqt_pkg::MODE_TIMER)
                    nxt.count = '0;
            end
        endcase
        res.link    = nxt.link;
        res.earlier = nxt.earlier;
        // reported count is taken before the timer clears it
        res.count   = (mode == nlqt_pkg::MODE_TIMER) ? cur.count : nxt.count;
    end

endmodule

`default_nettype wire

>>> rtl/neighbour_link_quality_tracker_unit.sv
// Neighbour link-quality tracker: per-neighbour state, earlier state and packet count.
// Path: the request stage with its memory read, then the result register.
// Throughput: one request per cycle while in_stall is low; the entry read-modify-write is a
// memory read, then an update and write, with write forwarding between requests.
// Reset: thresholds take their defaults, then a clearing pass zeroes the whole table
// with in_stall high. Depends on nlqt_pkg, nlqt_cfg_regs, nlqt_table and nlqt_update.
`default_nettype none

module neighbour_link_quality_tracker_unit #(
    parameter int NEIGHBOURS = nlqt_pkg::NEIGHBOURS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [nlqt_pkg::MODE_W-1:0]       mode,
    input  wire logic [nlqt_pkg::NB_W-1:0]         neighbour,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   changed,
    output logic [nlqt_pkg::STATE_W-1:0]           link_state,
    output logic [nlqt_pkg::STATE_W-1:0]           earlier_state,
    output logic [nlqt_pkg::COUNT_W-1:0]           packet_count,
    // register write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [nlqt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nlqt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = $clog2(NEIGHBOURS);
    localparam int XW = (AW > nlqt_pkg::NB_W) ? AW : nlqt_pkg::NB_W;

    nlqt_pkg::cfg_t    cfg;
    nlqt_pkg::entry_t  rd_data;
    nlqt_pkg::entry_t  cur;
    nlqt_pkg::entry_t  nxt;
    nlqt_pkg::res_t    res;
    logic              tbl_ready;

    logic              accept_in;
    logic              s1_adv;
    logic              wr_en;
    logic [XW-1:0]     nb_ext;
    logic [AW-1:0]     in_addr;
    logic              in_hit;

    // request stage: address and mode waiting for the memory read
    logic                   s1_valid_reg;
    logic [AW-1:0]          s1_addr_reg;
    nlqt_pkg::mode_t        s1_mode_reg;
    logic                   s1_hit_reg;

    // last written entry, covers a read racing the write of the same address
    logic                   fwd_valid_reg;
    logic [AW-1:0]          fwd_addr_reg;
    nlqt_pkg::entry_t       fwd_entry_reg;

    // result register
    logic                   out_valid_reg;
    nlqt_pkg::res_t         out_res_reg;

    assign cfg_ready = 1'b1;

    nlqt_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // address decode and range check
    assign nb_ext  = XW'(neighbour);
    assign in_addr = nb_ext[AW-1:0];
    assign in_hit  = (32'(neighbour) < NEIGHBOURS);

    // handshake control
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = !tbl_ready || (s1_valid_reg && out_valid_reg && out_stall);
    assign accept_in = in_valid && !in_stall;
    assign wr_en     = s1_adv && s1_hit_reg;

    nlqt_table #(
        .NEIGHBOURS (NEIGHBOURS),
        .AW         (AW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept_in),
        .rd_addr (in_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (nxt),
        .ready   (tbl_ready)
    );

    // pick the freshest copy of the entry
    assign cur = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_entry_reg : rd_data;

    nlqt_update u_update (
        .cur  (cur),
        .mode (s1_mode_reg),
        .cfg  (cfg),
        .nxt  (nxt),
        .res  (res)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept_in)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (wr_en)
                fwd_valid_reg <= 1'b1;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_addr_reg <= in_addr;
            s1_mode_reg <= nlqt_pkg::mode_t'(mode);
            s1_hit_reg  <= in_hit;
        end
        if (wr_en)
        begin
            fwd_addr_reg  <= s1_addr_reg;
            fwd_entry_reg <= nxt;
        end
        // out-of-range neighbours report all zero
        if (s1_adv)
            out_res_reg <= s1_hit_reg ? res : '0;
    end

    assign out_valid     = out_valid_reg;
    assign changed       = out_res_reg.changed;
    assign link_state    = out_res_reg.link;
    assign earlier_state = out_res_reg.earlier;
    assign packet_count  = out_res_reg.count;

endmodule

`default_nettype wire

>>> rtl/nlqt_checker.sv
// nlqt_checker: port-level assertions for the link-quality tracker
// bound to neighbour_link_quality_tracker_unit; depends on nlqt_pkg
`default_nettype none

module nlqt_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic [nlqt_pkg::MODE_W-1:0]       mode,
    input wire logic [nlqt_pkg::NB_W-1:0]         neighbour,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic                              changed,
    input wire logic [nlqt_pkg::STATE_W-1:0]      link_state,
    input wire logic [nlqt_pkg::STATE_W-1:0]      earlier_state,
    input wire logic [nlqt_pkg::COUNT_W-1:0]      packet_count,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic [nlqt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input wire logic [nlqt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(link_state) &&
            $stable(earlier_state) && $stable(packet_count) && $stable(changed))
        else $error("result changed while stalled");

    // table clearing keeps requests out right after reset
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_stall)
        else $error("request port open during table clearing");

    // an accepted move records a different earlier state
    a_changed_diff: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && changed |-> link_state != earlier_state)
        else $error("change reported with equal earlier state");

    // null is only ever re-entered from expired
    a_null_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (link_state == nlqt_pkg::ST_NULL) |->
            (earlier_state == nlqt_pkg::ST_NULL) || (earlier_state == nlqt_pkg::ST_EXPIRED))
        else $error("null state with impossible earlier state");

endmodule

bind neighbour_link_quality_tracker_unit nlqt_checker u_checker (.*);

`default_nettype wire
